// ===== rtl/alp_ts_decapsulator_defines.svh =====
// ----------------------------------------------------------------------------
// alp_ts_decapsulator_defines
// Assertion macros shared by the ALP to TS decapsulator RTL.
// ----------------------------------------------------------------------------
`ifndef ALP_TS_DECAPSULATOR_DEFINES_SVH
`define ALP_TS_DECAPSULATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define ALP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alp_ts: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define ALP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alp_ts: next-cycle check failed");

`endif

// ===== rtl/alp_ts_pkg.sv =====
// ----------------------------------------------------------------------------
// alp_ts_pkg
// Types and constants of the ALP to MPEG-2 TS decapsulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alp_ts_pkg;

  // TS framing constants
  localparam logic [7:0] TS_SYNC_BYTE   = 8'h47;
  localparam logic [7:0] TS_BODY_LEN    = 8'd187;  // bytes after sync, full header
  localparam logic [7:0] TS_PAYLOAD_LEN = 8'd184;  // bytes after sync, header removed
  localparam logic [4:0] TS_COUNT_ZERO  = 5'd16;   // count field 0 means 16
  localparam logic [7:0] HDR_CC_MASK    = 8'hF0;

  // Decoder phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HDR2 = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  // Results of one input word, handed to the output serializer
  typedef struct packed {
    logic            has_sync;   // word starts a TS packet
    logic            has_hdr;    // saved header is reinserted after sync
    logic [2:0][7:0] hdr;        // hdr[0] goes out first
    logic [7:0]      data;       // the input byte itself, always last
    logic            pkt_end;    // last byte of the link-layer packet
  } bundle_t;

endpackage

`default_nettype wire

// ===== rtl/alp_ts_core.sv =====
// ----------------------------------------------------------------------------
// alp_ts_core
// Header parse, TS packet tracking and header reinsertion for one input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "alp_ts_decapsulator_defines.svh"

module alp_ts_core #(
  parameter int MAX_TS_PER_PACKET = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         data_byte,
  input  wire logic               packet_start,
  output logic                    emit,
  output alp_ts_pkg::bundle_t     bundle
);

  alp_ts_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  pl_r, pl_nxt;
  logic [7:0]  bip_r, bip_nxt;
  logic        del_r, del_nxt;
  logic [23:0] saved_r, saved_nxt;
  logic [3:0]  cc_r, cc_nxt;
  logic        first_r, first_nxt;

  logic [4:0]  count_n;
  logic [4:0]  count_max;
  logic [7:0]  bip_inc;
  logic [7:0]  body_len;
  logic [4:0]  pl_dec;

  // Packet count from the first header byte, clamped to the parameter
  assign count_max = 5'(MAX_TS_PER_PACKET);
  always_comb begin
    count_n = (data_byte[4:1] == 4'd0) ? alp_ts_pkg::TS_COUNT_ZERO
                                        : {1'b0, data_byte[4:1]};
    if (count_n > count_max) begin
      count_n = count_max;
    end
  end

  assign bip_inc  = bip_r + 8'd1;
  assign pl_dec   = pl_r - 5'd1;
  assign body_len = (del_r && !first_r) ? alp_ts_pkg::TS_PAYLOAD_LEN
                                        : alp_ts_pkg::TS_BODY_LEN;

  // Next state and result bundle
  always_comb begin
    phase_nxt = phase_r;
    pl_nxt    = pl_r;
    bip_nxt   = bip_r;
    del_nxt   = del_r;
    saved_nxt = saved_r;
    cc_nxt    = cc_r;
    first_nxt = first_r;
    emit      = 1'b0;
    bundle.has_sync = (bip_r == 8'd0);
    bundle.has_hdr  = (bip_r == 8'd0) && del_r && !first_r;
    bundle.hdr[0]   = saved_r[23:16];
    bundle.hdr[1]   = saved_r[15:8];
    bundle.hdr[2]   = {saved_r[7:4], cc_r};
    bundle.data     = data_byte;
    bundle.pkt_end  = 1'b0;
    if (accept) begin
      if (packet_start) begin
        pl_nxt    = count_n;
        bip_nxt   = 8'd0;
        del_nxt   = 1'b0;
        first_nxt = 1'b1;
        phase_nxt = data_byte[0] ? alp_ts_pkg::PH_HDR2 : alp_ts_pkg::PH_DATA;
      end else begin
        case (phase_r)
          alp_ts_pkg::PH_HDR2: begin
            del_nxt   = data_byte[7];
            phase_nxt = alp_ts_pkg::PH_DATA;
          end
          alp_ts_pkg::PH_DATA: begin
            emit = 1'b1;
            if (bundle.has_hdr) begin
              cc_nxt = cc_r + 4'd1;
            end
            // capture the first packet's header for later reinsertion
            if (del_r && first_r) begin
              case (bip_r)
                8'd0: saved_nxt[23:16] = data_byte;
                8'd1: saved_nxt[15:8]  = data_byte;
                8'd2: begin
                  saved_nxt[7:0] = data_byte & alp_ts_pkg::HDR_CC_MASK;
                  cc_nxt         = data_byte[3:0] + 4'd1;
                end
                default: ;
              endcase
            end
            bip_nxt = bip_inc;
            if (bip_inc >= body_len) begin
              bip_nxt   = 8'd0;
              first_nxt = 1'b0;
              pl_nxt    = pl_dec;
              if (pl_dec == 5'd0) begin
                phase_nxt      = alp_ts_pkg::PH_IDLE;
                bundle.pkt_end = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= alp_ts_pkg::PH_IDLE;
      pl_r    <= 5'd0;
      bip_r   <= 8'd0;
      del_r   <= 1'b0;
      saved_r <= 24'd0;
      cc_r    <= 4'd0;
      first_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      pl_r    <= pl_nxt;
      bip_r   <= bip_nxt;
      del_r   <= del_nxt;
      saved_r <= saved_nxt;
      cc_r    <= cc_nxt;
      first_r <= first_nxt;
    end
  end

  // Byte position never reaches the packet length
  `ALP_ASSERT_IMP(a_bip_range, clk, rst_n, 1'b1, bip_r < alp_ts_pkg::TS_BODY_LEN)
  // While in data, at least one TS packet remains
  `ALP_ASSERT_IMP(a_pl_live, clk, rst_n, phase_r == alp_ts_pkg::PH_DATA, pl_r != 5'd0)
  // Reinserted header only after the first packet has been seen in full
  `ALP_ASSERT_IMP(a_hdr_after_first, clk, rst_n, emit && bundle.has_hdr, !first_r && del_r)

endmodule

`default_nettype wire

// ===== rtl/alp_ts_ser.sv =====
// ----------------------------------------------------------------------------
// alp_ts_ser
// Result register: holds one word's bundle and sends its bytes out in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "alp_ts_decapsulator_defines.svh"

module alp_ts_ser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire alp_ts_pkg::bundle_t bundle,
  output logic                     slot_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               ts_byte,
  output logic                     ts_sync,
  output logic                     pkt_end,
  output logic                     last
);

  alp_ts_pkg::bundle_t bnd_r, bnd_nxt;
  logic       valid_r, valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] last_idx;
  logic       out_fire;

  // Position of the data byte: after sync and optional three header bytes
  assign last_idx = bnd_r.has_hdr ? 3'd4 : (bnd_r.has_sync ? 3'd1 : 3'd0);
  assign last     = (idx_r == last_idx);
  assign out_valid = valid_r;
  assign out_fire  = valid_r && out_ready;
  assign slot_free = !valid_r || (out_fire && last);

  // Byte select
  always_comb begin
    if (last) begin
      ts_byte = bnd_r.data;
    end else if (idx_r == 3'd0) begin
      ts_byte = alp_ts_pkg::TS_SYNC_BYTE;
    end else begin
      ts_byte = bnd_r.hdr[2'(idx_r - 3'd1)];
    end
  end
  assign ts_sync = bnd_r.has_sync && (idx_r == 3'd0);
  assign pkt_end = bnd_r.pkt_end && last;

  // Walk through the bundle, reload on a new word
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    bnd_nxt   = bnd_r;
    if (out_fire) begin
      if (last) begin
        valid_nxt = 1'b0;
        idx_nxt   = 3'd0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 3'd0;
      bnd_nxt   = bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bnd_r <= bnd_nxt;
  end

  // A new bundle never overwrites one that still has bytes to send
  `ALP_ASSERT_IMP(a_no_overwrite, clk, rst_n, load && valid_r, out_ready && last)
  // Index stays inside the bundle
  `ALP_ASSERT_IMP(a_idx_range, clk, rst_n, valid_r, idx_r <= last_idx)
  // A stalled bundle keeps its position
  `ALP_ASSERT_NXT(a_idx_hold, clk, rst_n, valid_r && !out_ready && !load,
                  idx_r == $past(idx_r))

endmodule

`default_nettype wire

// ===== rtl/alp_ts_decapsulator.sv =====
// Output: the first result byte of a word is registered, valid in the cycle after acceptance.
// Throughput: one input word per cycle while out_tready holds and words yield at most one
//   byte; a longer word holds the input until its last byte goes (TS start: 2 bytes, with
//   reinserted header: 5): the single result register drains one byte per ready cycle.
// Reset: synchronous, active low; decoder goes idle, result register empties, no bytes pending.
// ----------------------------------------------------------------------------
// alp_ts_decapsulator
// Rebuilds 188-byte MPEG-2 TS packets from an ATSC 3.0 link-layer byte stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alp_ts_decapsulator #(
  parameter int MAX_TS_PER_PACKET = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] packet_start
  // result stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] ts_byte
  output logic [1:0]      out_tuser,  // [0] ts_sync, [1] packet_end
  output logic            out_tlast   // last_of_run
);

  logic                accept;
  logic                emit;
  logic                slot_free;
  alp_ts_pkg::bundle_t bundle;

  assign in_tready = slot_free;
  assign accept    = in_tvalid && slot_free;

  // Per-word decode
  alp_ts_core #(
    .MAX_TS_PER_PACKET (MAX_TS_PER_PACKET)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_tdata),
    .packet_start (in_tuser),
    .emit         (emit),
    .bundle       (bundle)
  );

  // Result register and byte serializer
  alp_ts_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && emit),
    .bundle    (bundle),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ts_byte   (out_tdata),
    .ts_sync   (out_tuser[0]),
    .pkt_end   (out_tuser[1]),
    .last      (out_tlast)
  );

endmodule

`default_nettype wire
